// ===== hdl/pitc_pkg.sv =====
// ----------------------------------------------------------------------------
// pitc_pkg : shared constants for the prescaled interval timer
// Widths of the catch-up datapath, register indexes and fixed limits.
// ----------------------------------------------------------------------------
package pitc_pkg;

    // Configuration register indexes
    localparam logic CFG_TIMER_ENABLE  = 1'b0;
    localparam logic CFG_TARGET_PERIOD = 1'b1;

    // Field widths
    localparam int CLOCKS_W = 16;
    localparam int COUNT_W  = 8;
    localparam int OUT_W    = 4;
    localparam int HIT_W    = 16;

    // Divider datapath: dividend covers prescale + clocks (up to 65790)
    localparam int DIVIDEND_W = CLOCKS_W + 1;
    localparam int DIVISOR_W  = COUNT_W + 1;
    localparam int STEP_W     = 5;
    localparam int DIV_STEPS  = DIVIDEND_W;

    // Divider wrap: a target of zero means a full 256-step period
    localparam logic [DIVISOR_W-1:0] DIVIDER_WRAP = 9'd256;
    localparam logic [HIT_W-1:0]     HIT_MAX      = 16'hFFFF;

endpackage

// ===== hdl/prescaled_interval_timer_catchup.sv =====
// ----------------------------------------------------------------------------
// prescaled_interval_timer_catchup : three-stage timer with closed-form catch-up
// Prescaler, 8-bit divider with compare and 4-bit output counter, advanced by
// a whole number of clocks per transfer using one shared restoring divider.
// ----------------------------------------------------------------------------
// Each input transfer carries a count of elapsed clocks; the timer moves
// exactly as if it had seen that many single ticks and returns one result
// (output counter, divider value, hits during the advance, saturated at
// 65535). Internally a single restoring divider, one quotient bit per cycle,
// first splits prescaler + clocks by PRESCALE_RATIO and then, when the
// divider passes its target, splits the remaining rollovers by the period.
// With the output register free, ST_DONE loads the result into it: m_valid
// rises and s_ready returns in the same cycle, so one item is in work at a
// time. s_ready is high only while no item is in work.
// A finished result waits in the output register, and the next item can be
// accepted while it waits.
// Configuration registers are written by cfg_wr_en with cfg_index and
// cfg_data: index 0 is timer_enable (bit 0), index 1 is target_period.
// ----------------------------------------------------------------------------
module prescaled_interval_timer_catchup #(
    parameter int PRESCALE_RATIO = 128
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [pitc_pkg::COUNT_W-1:0] cfg_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pitc_pkg::CLOCKS_W-1:0] s_elapsed_clocks,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pitc_pkg::OUT_W-1:0]   m_output_count,
    output logic [pitc_pkg::COUNT_W-1:0] m_divider_value,
    output logic [pitc_pkg::HIT_W-1:0]   m_hit_count
);

    localparam int DW  = pitc_pkg::DIVIDEND_W;
    localparam int VW  = pitc_pkg::DIVISOR_W;
    localparam int CW  = pitc_pkg::COUNT_W;
    localparam int SW  = pitc_pkg::STEP_W;
    localparam logic [VW-1:0] RATIO_DIV = VW'(PRESCALE_RATIO);
    localparam logic [SW-1:0] LAST_STEP = SW'(pitc_pkg::DIV_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_ROLLS,
        ST_POST_ROLLS,
        ST_DIV_HITS,
        ST_POST_HITS,
        ST_DONE
    } state_t;

    // Control and architectural state
    state_t                     state_reg, state_next;
    logic                       enable_reg, enable_next;
    logic [CW-1:0]              target_reg, target_next;
    logic [CW-1:0]              prescale_reg, prescale_next;
    logic [CW-1:0]              divider_reg, divider_next;
    logic [pitc_pkg::OUT_W-1:0] outcnt_reg, outcnt_next;
    logic [pitc_pkg::HIT_W-1:0] hits_reg, hits_next;
    logic                       m_valid_reg, m_valid_next;
    logic [pitc_pkg::OUT_W-1:0] m_count_reg, m_count_next;
    logic [CW-1:0]              m_div_reg, m_div_next;
    logic [pitc_pkg::HIT_W-1:0] m_hits_reg, m_hits_next;

    // Shared divider datapath
    logic [DW-1:0] quo_reg, quo_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [VW-1:0] divisor_reg, divisor_next;
    logic [SW-1:0] step_reg, step_next;

    logic [VW-1:0] shifted;
    logic [VW:0]   trial;
    logic          fits;
    logic [CW-1:0] first_gap;
    logic [VW-1:0] first_rolls;
    logic [VW-1:0] period;
    logic          short_advance;
    logic [DW-1:0] rest_rolls;
    logic [DW-1:0] hits_full;
    logic          out_free;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign trial   = {1'b0, shifted} - {1'b0, divisor_reg};
    assign fits    = ~trial[VW];

    // Rollovers until the first hit; a divider already at target needs a full wrap
    assign first_gap     = target_reg - divider_reg;
    assign first_rolls   = (first_gap == '0) ? pitc_pkg::DIVIDER_WRAP : {1'b0, first_gap};
    assign period        = (target_reg == '0) ? pitc_pkg::DIVIDER_WRAP : {1'b0, target_reg};
    assign short_advance = quo_reg < {{(DW-VW){1'b0}}, first_rolls};
    assign rest_rolls    = quo_reg - {{(DW-VW){1'b0}}, first_rolls};
    assign hits_full     = quo_reg + DW'(1);

    assign out_free = ~m_valid_reg | m_ready;

    always_comb begin
        state_next    = state_reg;
        enable_next   = enable_reg;
        target_next   = target_reg;
        prescale_next = prescale_reg;
        divider_next  = divider_reg;
        outcnt_next   = outcnt_reg;
        hits_next     = hits_reg;
        m_valid_next  = m_valid_reg;
        m_count_next  = m_count_reg;
        m_div_next    = m_div_reg;
        m_hits_next   = m_hits_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        divisor_next  = divisor_reg;
        step_next     = step_reg;

        // Drop the result once the downstream side takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            case (cfg_index)
                pitc_pkg::CFG_TIMER_ENABLE:  enable_next = cfg_data[0];
                pitc_pkg::CFG_TARGET_PERIOD: target_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    quo_next     = {{(DW-CW){1'b0}}, prescale_reg}
                                 + {1'b0, s_elapsed_clocks};
                    rem_next     = '0;
                    divisor_next = RATIO_DIV;
                    step_next    = '0;
                    hits_next    = '0;
                    state_next   = ST_DIV_ROLLS;
                end
            end
            ST_DIV_ROLLS, ST_DIV_HITS: begin
                quo_next  = {quo_reg[DW-2:0], fits};
                rem_next  = fits ? trial[CW-1:0] : shifted[CW-1:0];
                step_next = step_reg + SW'(1);
                if (step_reg == LAST_STEP) begin
                    state_next = (state_reg == ST_DIV_ROLLS) ? ST_POST_ROLLS : ST_POST_HITS;
                end
            end
            ST_POST_ROLLS: begin
                // quo holds the rollover count, rem the new prescaler value
                prescale_next = rem_reg;
                state_next    = ST_DONE;
                if (enable_reg && (quo_reg != '0)) begin
                    if (short_advance) begin
                        divider_next = divider_reg + quo_reg[CW-1:0];
                    end else begin
                        quo_next     = rest_rolls;
                        rem_next     = '0;
                        divisor_next = period;
                        step_next    = '0;
                        state_next   = ST_DIV_HITS;
                    end
                end
            end
            ST_POST_HITS: begin
                divider_next = rem_reg;
                outcnt_next  = outcnt_reg + hits_full[pitc_pkg::OUT_W-1:0];
                hits_next    = hits_full[DW-1] ? pitc_pkg::HIT_MAX
                                               : hits_full[pitc_pkg::HIT_W-1:0];
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_count_next = outcnt_reg;
                    m_div_next   = divider_reg;
                    m_hits_next  = hits_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            enable_reg   <= 1'b0;
            target_reg   <= '0;
            prescale_reg <= '0;
            divider_reg  <= '0;
            outcnt_reg   <= '0;
            hits_reg     <= '0;
            m_valid_reg  <= 1'b0;
            m_count_reg  <= '0;
            m_div_reg    <= '0;
            m_hits_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            enable_reg   <= enable_next;
            target_reg   <= target_next;
            prescale_reg <= prescale_next;
            divider_reg  <= divider_next;
            outcnt_reg   <= outcnt_next;
            hits_reg     <= hits_next;
            m_valid_reg  <= m_valid_next;
            m_count_reg  <= m_count_next;
            m_div_reg    <= m_div_next;
            m_hits_reg   <= m_hits_next;
        end
    end

    // Divider datapath carries no reset; it is loaded before every use
    always_ff @(posedge aclk) begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        step_reg    <= step_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_output_count  = m_count_reg;
    assign m_divider_value = m_div_reg;
    assign m_hit_count     = m_hits_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : testbench for prescaled_interval_timer_catchup
// Drives elapsed-clock transfers under several timer settings, predicts the
// output counter, divider and hit count with a cycle-free timer model, and
// checks every result transfer in order against the predicted values.
// ----------------------------------------------------------------------------
module tb;

    localparam int PRESCALE_RATIO = 128;
    localparam int CLOCKS_W       = pitc_pkg::CLOCKS_W;
    localparam int COUNT_W        = pitc_pkg::COUNT_W;
    localparam int OUT_W          = pitc_pkg::OUT_W;
    localparam int HIT_W          = pitc_pkg::HIT_W;

    typedef struct packed {
        logic [OUT_W-1:0]   out_count;
        logic [COUNT_W-1:0] divider;
        logic [HIT_W-1:0]   hits;
    } timer_result_t;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    // ------------------------------------------------------------------------
    // DUT signals; the inputs are driven to known values from time zero
    // ------------------------------------------------------------------------
    logic                aclk             = 1'b0;
    logic                aresetn          = 1'b0;
    logic                cfg_wr_en        = 1'b0;
    logic                cfg_index        = pitc_pkg::CFG_TIMER_ENABLE;
    logic [COUNT_W-1:0]  cfg_data         = '0;
    logic                s_valid          = 1'b0;
    logic                s_ready;
    logic [CLOCKS_W-1:0] s_elapsed_clocks = '0;
    logic                m_valid;
    logic                m_ready          = 1'b0;
    logic [OUT_W-1:0]    m_output_count;
    logic [COUNT_W-1:0]  m_divider_value;
    logic [HIT_W-1:0]    m_hit_count;

    prescaled_interval_timer_catchup #(
        .PRESCALE_RATIO(PRESCALE_RATIO)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_elapsed_clocks(s_elapsed_clocks),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_output_count  (m_output_count),
        .m_divider_value (m_divider_value),
        .m_hit_count     (m_hit_count)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Timer model state: shadow copies of the registers and the three stages
    // ------------------------------------------------------------------------
    logic               tmr_enable   = 1'b0;
    logic [COUNT_W-1:0] tmr_target   = '0;
    logic [COUNT_W-1:0] tmr_prescale = '0;
    logic [COUNT_W-1:0] tmr_divider  = '0;
    logic [OUT_W-1:0]   tmr_out      = '0;

    timer_result_t pending_results[$];
    timer_result_t head_result;
    int            error_count = 0;

    // Sender and receiver behavior knobs
    logic     tx_eager      = 1'b0;
    int       tx_gap_max    = 8;
    int       tx_burst_left = 0;
    rx_mode_t rx_mode       = RX_RANDOM;
    int       rx_hold_cycles = 0;
    logic [2:0] rx_phase    = '0;
    logic [7:0] rx_pattern  = 8'b1011_0010;

    // Advance the timer model by a number of clocks in one step, the way a
    // run of single ticks would: prescaler rollovers feed the divider, and
    // each time the incremented divider meets the target it clears and the
    // output counter steps.
    function automatic timer_result_t advance_timer(input logic [CLOCKS_W-1:0] clocks);
        int unsigned        total;
        int unsigned        rolls;
        int unsigned        period;
        int unsigned        first_hit;
        int unsigned        rest;
        int unsigned        hits;
        logic [COUNT_W-1:0] gap;
        timer_result_t      res;
        total        = 32'(tmr_prescale) + 32'(clocks);
        rolls        = total / 32'(PRESCALE_RATIO);
        hits         = 0;
        tmr_prescale = COUNT_W'(total % 32'(PRESCALE_RATIO));
        if (tmr_enable && rolls != 0) begin
            period = (tmr_target != 0) ? 32'(tmr_target) : 32'(pitc_pkg::DIVIDER_WRAP);
            // Steps until the next match; a divider already at the target
            // increments first, so a full wrap is needed.
            gap       = tmr_target - tmr_divider;
            first_hit = (gap == 0) ? 32'(pitc_pkg::DIVIDER_WRAP) : 32'(gap);
            if (rolls < first_hit) begin
                tmr_divider = COUNT_W'(tmr_divider + rolls);
            end else begin
                rest        = rolls - first_hit;
                hits        = 1 + rest / period;
                tmr_divider = COUNT_W'(rest % period);
                tmr_out     = tmr_out + OUT_W'(hits);
            end
        end
        if (hits > 32'(pitc_pkg::HIT_MAX))
            hits = 32'(pitc_pkg::HIT_MAX);
        res.out_count = tmr_out;
        res.divider   = tmr_divider;
        res.hits      = HIT_W'(hits);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: every result transfer pops the oldest prediction
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer: expected none, actual %0d/%0d/%0d",
                         $time, m_output_count, m_divider_value, m_hit_count);
                error_count++;
            end else begin
                head_result = pending_results.pop_front();
                check_field("output_count", int'(head_result.out_count), int'(m_output_count));
                check_field("divider_value", int'(head_result.divider), int'(m_divider_value));
                check_field("hit_count", int'(head_result.hits), int'(m_hit_count));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall on its own pattern; a requested hold-off is counted here
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold_cycles - 1) @(negedge aclk);
                rx_hold_cycles = 0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  m_ready <= 1'b1;
                    RX_RANDOM:  m_ready <= ($urandom_range(0, 3) != 0);
                    RX_PATTERN: begin
                        m_ready  <= rx_pattern[rx_phase];
                        rx_phase <= rx_phase + 3'd1;
                    end
                    default:    m_ready <= 1'b1;
                endcase
            end
        end
    end

    // Timeout guard: far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------------

    // Offer one transfer, hold it until accepted, then predict its result.
    // Between bursts drop valid for a random gap.
    task automatic send_clocks(input logic [CLOCKS_W-1:0] clocks);
        @(negedge aclk);
        s_valid          <= 1'b1;
        s_elapsed_clocks <= clocks;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(advance_timer(clocks));
        if (!tx_eager) begin
            if (tx_burst_left == 0) begin
                tx_burst_left = $urandom_range(1, 8);
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat ($urandom_range(0, tx_gap_max)) @(negedge aclk);
            end else begin
                tx_burst_left--;
            end
        end
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [COUNT_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == pitc_pkg::CFG_TIMER_ENABLE)
            tmr_enable = data[0];
        else
            tmr_target = data;
    endtask

    // Reprogram both registers once the timer is idle. Upper bits of the
    // enable write are don't-care, so scramble them.
    task automatic set_config(input logic en, input logic [COUNT_W-1:0] target);
        logic [COUNT_W-1:0] en_word;
        drain_results();
        en_word    = COUNT_W'($urandom_range(0, 255));
        en_word[0] = en;
        write_reg(pitc_pkg::CFG_TIMER_ENABLE, en_word);
        write_reg(pitc_pkg::CFG_TARGET_PERIOD, target);
    endtask

    // Mix of small advances, advances near whole prescaler rollovers and
    // full-range advances
    function automatic logic [CLOCKS_W-1:0] pick_clocks();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return CLOCKS_W'($urandom_range(0, 1023));
        else if (sel < 6)
            return CLOCKS_W'(PRESCALE_RATIO * $urandom_range(0, 511)
                             + $urandom_range(0, 2) - 1);
        else
            return CLOCKS_W'($urandom_range(0, 65535));
    endfunction

    // Targets: extremes, equal to the divider, below the divider, or random
    function automatic logic [COUNT_W-1:0] pick_target();
        case ($urandom_range(0, 6))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd255;
            3: return tmr_divider;
            4: return (tmr_divider != 0) ? COUNT_W'($urandom_range(0, tmr_divider - 1))
                                         : 8'd0;
            default: return COUNT_W'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Timer disabled after reset: prescaler moves, divider and counter hold
    task automatic test_disabled_after_reset();
        send_clocks(16'd0);
        send_clocks(16'd65535);
        send_clocks(16'd1);
        send_clocks(16'd127);
    endtask

    // Period extremes: target 0 (full wrap), target 1 (many hits, counter
    // wraps), target 255; includes zero clocks and a divider sitting at the
    // target when an advance starts
    task automatic test_period_extremes();
        set_config(1'b1, 8'd0);
        send_clocks(16'd0);
        send_clocks(16'd65535);
        send_clocks(16'd128);
        send_clocks(16'd32768);
        set_config(1'b1, 8'd1);
        send_clocks(16'd65535);
        send_clocks(16'd16383);
        set_config(1'b1, 8'd255);
        send_clocks(16'(PRESCALE_RATIO * 254));
        send_clocks(16'(PRESCALE_RATIO));
        send_clocks(16'd256);
    endtask

    // Lower the target below the divider so it must wrap through 255, then
    // set the target equal to the divider
    task automatic test_target_moves();
        set_config(1'b1, 8'd200);
        send_clocks(16'(PRESCALE_RATIO * 100));
        set_config(1'b1, 8'd50);
        send_clocks(16'd65535);
        set_config(1'b1, tmr_divider);
        send_clocks(16'd65535);
    endtask

    // Disable mid-count: divider and output counter must hold
    task automatic test_disable_holds();
        set_config(1'b0, 8'd7);
        send_clocks(16'd5000);
        send_clocks(16'(PRESCALE_RATIO));
    endtask

    // Hold the receiver off for a long stretch while the sender keeps
    // offering, so the block fills up and backs up its input
    task automatic test_backpressure();
        set_config(1'b1, 8'd3);
        tx_eager       = 1'b1;
        rx_mode        = RX_ALWAYS;
        rx_hold_cycles = 400;
        repeat (8) send_clocks(pick_clocks());
        drain_results();
        tx_eager = 1'b0;
    endtask

    // Random phases: new settings, new idling behavior, random advances
    task automatic test_random_phases(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            set_config($urandom_range(0, 6) != 0, pick_target());
            tx_eager   = ($urandom_range(0, 3) == 0);
            tx_gap_max = $urandom_range(1, 20);
            rx_mode    = rx_mode_t'($urandom_range(0, 2));
            rx_pattern = 8'($urandom_range(1, 255));
            for (int i = 0; i < per_phase; i++)
                send_clocks(pick_clocks());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        test_disabled_after_reset();
        test_period_extremes();
        test_target_moves();
        test_disable_holds();
        test_backpressure();
        test_random_phases(13, 100);

        drain_results();
        repeat (50) @(posedge aclk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
